// File: rtl/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared widths, limits and register codes of the int8 matmul tile.
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int unsigned MaxRows     = 8;
  localparam int unsigned MaxCols     = 4;
  localparam int unsigned DefTileRows = 8;
  localparam int unsigned DefTileCols = 4;

  localparam int unsigned DataW   = 8;
  localparam int unsigned AccW    = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned RowIdxW = 3;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // Register index, taken from paddr word bits
  typedef enum logic [0:0] {
    RegDotLength = 1'b0,
    RegNone      = 1'b1
  } mmt_reg_e;

  localparam logic [LenW-1:0] DotLengthRst = LenW'(1);

endpackage

// File: rtl/mmt_in_if.sv
// ----------------------------------------------------------------------------
// mmt_in_if
// Input channel: one reduction step with eight A and four B operands.
// ----------------------------------------------------------------------------
interface mmt_in_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [mmt_pkg::DataW-1:0]      a_row0;
  logic signed [mmt_pkg::DataW-1:0]      a_row1;
  logic signed [mmt_pkg::DataW-1:0]      a_row2;
  logic signed [mmt_pkg::DataW-1:0]      a_row3;
  logic signed [mmt_pkg::DataW-1:0]      a_row4;
  logic signed [mmt_pkg::DataW-1:0]      a_row5;
  logic signed [mmt_pkg::DataW-1:0]      a_row6;
  logic signed [mmt_pkg::DataW-1:0]      a_row7;
  logic signed [mmt_pkg::DataW-1:0]      b_col0;
  logic signed [mmt_pkg::DataW-1:0]      b_col1;
  logic signed [mmt_pkg::DataW-1:0]      b_col2;
  logic signed [mmt_pkg::DataW-1:0]      b_col3;

  modport source (
    output valid, a_row0, a_row1, a_row2, a_row3, a_row4, a_row5, a_row6, a_row7,
    output b_col0, b_col1, b_col2, b_col3,
    input  ready
  );

  modport sink (
    input  valid, a_row0, a_row1, a_row2, a_row3, a_row4, a_row5, a_row6, a_row7,
    input  b_col0, b_col1, b_col2, b_col3,
    output ready
  );

endinterface

// File: rtl/mmt_out_if.sv
// ----------------------------------------------------------------------------
// mmt_out_if
// Result channel: the four column sums of one tile row.
// ----------------------------------------------------------------------------
interface mmt_out_if;

  logic                                valid;
  logic                                ready;
  logic        [mmt_pkg::RowIdxW-1:0]  row_index;
  logic signed [mmt_pkg::AccW-1:0]     sum_col0;
  logic signed [mmt_pkg::AccW-1:0]     sum_col1;
  logic signed [mmt_pkg::AccW-1:0]     sum_col2;
  logic signed [mmt_pkg::AccW-1:0]     sum_col3;
  logic                                last_row;

  modport source (
    output valid, row_index, sum_col0, sum_col1, sum_col2, sum_col3, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_index, sum_col0, sum_col1, sum_col2, sum_col3, last_row,
    output ready
  );

endinterface

// File: rtl/int8_matmul_tile_wrap16.sv
// ----------------------------------------------------------------------------
// int8_matmul_tile_wrap16
// Output-stationary int8 GEMM tile with wrapping 16-bit accumulators.
// ----------------------------------------------------------------------------
// Each input item is one reduction step and is taken at one item per clock:
// while no closing step is held: it is registered in the input register,
// then all TILE_ROWS x TILE_COLS multiply-accumulates update together. When
// the step count reaches dot_length (zero counts as one) the sums go to a
// result bank and the accumulators clear, so the next tile starts at once.
// The bank drains over the single result port, one row per cycle while the
// receiver is ready. The closing item passes the input register, then its
// sums are registered into the bank and the first row is shown. A step that
// would close a tile waits while the bank still drains.
// ----------------------------------------------------------------------------
module int8_matmul_tile_wrap16 #(
  parameter int unsigned TileRows = mmt_pkg::DefTileRows,
  parameter int unsigned TileCols = mmt_pkg::DefTileCols
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mmt_in_if.sink                         in_i,
  mmt_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mmt_pkg::ApbAddrW-1:0]   paddr,
  input  logic [mmt_pkg::ApbDataW-1:0]   pwdata,
  output logic [mmt_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  logic [mmt_pkg::LenW-1:0]         dot_length;
  logic signed [mmt_pkg::DataW-1:0] a_vec [mmt_pkg::MaxRows];
  logic signed [mmt_pkg::DataW-1:0] b_vec [mmt_pkg::MaxCols];
  logic [mmt_pkg::AccW-1:0]         sums [TileRows][TileCols];
  logic [mmt_pkg::AccW-1:0]         sum_out [mmt_pkg::MaxCols];
  logic                             tile_done;
  logic                             bank_busy;

  assign a_vec[0] = in_i.a_row0;
  assign a_vec[1] = in_i.a_row1;
  assign a_vec[2] = in_i.a_row2;
  assign a_vec[3] = in_i.a_row3;
  assign a_vec[4] = in_i.a_row4;
  assign a_vec[5] = in_i.a_row5;
  assign a_vec[6] = in_i.a_row6;
  assign a_vec[7] = in_i.a_row7;
  assign b_vec[0] = in_i.b_col0;
  assign b_vec[1] = in_i.b_col1;
  assign b_vec[2] = in_i.b_col2;
  assign b_vec[3] = in_i.b_col3;

  mmt_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .dot_length_o (dot_length)
  );

  mmt_mac #(
    .TileRows (TileRows),
    .TileCols (TileCols)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .a_i          (a_vec),
    .b_i          (b_vec),
    .dot_length_i (dot_length),
    .bank_busy_i  (bank_busy),
    .tile_done_o  (tile_done),
    .sums_o       (sums)
  );

  mmt_drain #(
    .TileRows (TileRows),
    .TileCols (TileCols)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tile_done),
    .sums_i      (sums),
    .busy_o      (bank_busy),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .row_index_o (out_o.row_index),
    .sum_o       (sum_out),
    .last_row_o  (out_o.last_row)
  );

  assign out_o.sum_col0 = sum_out[0];
  assign out_o.sum_col1 = sum_out[1];
  assign out_o.sum_col2 = sum_out[2];
  assign out_o.sum_col3 = sum_out[3];

endmodule

// File: rtl/mmt_cfg.sv
// ----------------------------------------------------------------------------
// mmt_cfg
// APB register file holding the reduction length of a tile.
// ----------------------------------------------------------------------------
module mmt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mmt_pkg::ApbAddrW-1:0]   paddr,
  input  logic [mmt_pkg::ApbDataW-1:0]   pwdata,
  output logic [mmt_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output logic [mmt_pkg::LenW-1:0]       dot_length_o
);

  logic [mmt_pkg::LenW-1:0] dot_length_q, dot_length_d;
  mmt_pkg::mmt_reg_e        reg_sel;
  logic                     wr_en;

  assign reg_sel = mmt_pkg::mmt_reg_e'(paddr[mmt_pkg::ApbAddrW-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    dot_length_d = dot_length_q;
    prdata       = '0;
    unique case (reg_sel)
      mmt_pkg::RegDotLength: begin
        prdata = mmt_pkg::ApbDataW'(dot_length_q);
        if (wr_en) begin
          dot_length_d = pwdata[mmt_pkg::LenW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_length_q <= mmt_pkg::DotLengthRst;
    end else begin
      dot_length_q <= dot_length_d;
    end
  end

  assign dot_length_o = dot_length_q;

endmodule

// File: rtl/mmt_mac.sv
// ----------------------------------------------------------------------------
// mmt_mac
// Input register, TileRows x TileCols (default 8x4) array of wrapping 16-bit multiply-accumulates and the
// reduction step counter that closes a tile.
// ----------------------------------------------------------------------------
module mmt_mac #(
  parameter int unsigned TileRows = mmt_pkg::DefTileRows,
  parameter int unsigned TileCols = mmt_pkg::DefTileCols
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [mmt_pkg::DataW-1:0] a_i [mmt_pkg::MaxRows],
  input  logic signed [mmt_pkg::DataW-1:0] b_i [mmt_pkg::MaxCols],
  input  logic [mmt_pkg::LenW-1:0]       dot_length_i,
  input  logic                           bank_busy_i,
  output logic                           tile_done_o,
  output logic [mmt_pkg::AccW-1:0]       sums_o [TileRows][TileCols]
);

  localparam int unsigned CntW = mmt_pkg::LenW + 1;

  logic                            in_vld_q;
  logic signed [mmt_pkg::DataW-1:0] a_q [TileRows];
  logic signed [mmt_pkg::DataW-1:0] b_q [TileCols];
  logic [mmt_pkg::LenW-1:0]        step_q;
  logic [CntW-1:0]                 step_next;
  logic [CntW-1:0]                 limit;
  logic                            tile_end;
  logic                            consume;
  logic                            take;

  assign step_next = {1'b0, step_q} + CntW'(1);
  // A zero length closes a tile on every step
  assign limit     = (dot_length_i == '0) ? CntW'(1) : {1'b0, dot_length_i};
  assign tile_end  = (step_next >= limit);

  // Hold the step when it would close a tile while the last one still drains
  assign consume     = in_vld_q && (!tile_end || !bank_busy_i);
  assign in_ready_o  = !in_vld_q || consume;
  assign take        = in_valid_i && in_ready_o;
  assign tile_done_o = consume && tile_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  for (genvar r = 0; r < TileRows; r++) begin : g_a_reg
    always_ff @(posedge clk_i) begin
      if (take) begin
        a_q[r] <= a_i[r];
      end
    end
  end

  for (genvar c = 0; c < TileCols; c++) begin : g_b_reg
    always_ff @(posedge clk_i) begin
      if (take) begin
        b_q[c] <= b_i[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (consume) begin
      step_q <= tile_end ? '0 : step_next[mmt_pkg::LenW-1:0];
    end
  end

  for (genvar r = 0; r < TileRows; r++) begin : g_row
    for (genvar c = 0; c < TileCols; c++) begin : g_col
      logic [mmt_pkg::AccW-1:0] a_ext, b_ext, prod, acc_q, acc_d;

      assign a_ext = {{(mmt_pkg::AccW-mmt_pkg::DataW){a_q[r][mmt_pkg::DataW-1]}}, a_q[r]};
      assign b_ext = {{(mmt_pkg::AccW-mmt_pkg::DataW){b_q[c][mmt_pkg::DataW-1]}}, b_q[c]};
      // Low 16 bits of the sign-extended product equal the wrapped signed product
      assign prod  = a_ext * b_ext;
      assign acc_d = acc_q + prod;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          acc_q <= '0;
        end else if (consume) begin
          acc_q <= tile_end ? '0 : acc_d;
        end
      end

      assign sums_o[r][c] = acc_d;
    end
  end

endmodule

// File: rtl/mmt_drain.sv
// ----------------------------------------------------------------------------
// mmt_drain
// Result bank: captures a finished tile and sends it out one row per item.
// ----------------------------------------------------------------------------
module mmt_drain #(
  parameter int unsigned TileRows = mmt_pkg::DefTileRows,
  parameter int unsigned TileCols = mmt_pkg::DefTileCols
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [mmt_pkg::AccW-1:0]          sums_i [TileRows][TileCols],
  output logic                              busy_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mmt_pkg::RowIdxW-1:0]       row_index_o,
  output logic [mmt_pkg::AccW-1:0]          sum_o [mmt_pkg::MaxCols],
  output logic                              last_row_o
);

  localparam int unsigned RowW = (TileRows > 1) ? $clog2(TileRows) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(TileRows - 1);

  logic [mmt_pkg::AccW-1:0] bank_q [TileRows][TileCols];
  logic                     busy_q;
  logic [RowW-1:0]          row_q;
  logic                     pop;
  logic                     at_last;

  assign at_last = (row_q == LastRow);
  assign pop     = busy_q && out_ready_i;

  for (genvar r = 0; r < TileRows; r++) begin : g_row
    for (genvar c = 0; c < TileCols; c++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (load_i) begin
          bank_q[r][c] <= sums_i[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      row_q  <= '0;
    end else if (pop) begin
      busy_q <= !at_last;
      row_q  <= at_last ? '0 : row_q + RowW'(1);
    end
  end

  for (genvar c = 0; c < mmt_pkg::MaxCols; c++) begin : g_out
    if (c < TileCols) begin : g_used
      assign sum_o[c] = bank_q[row_q][c];
    end else begin : g_unused
      assign sum_o[c] = '0;
    end
  end

  // Free the bank for a new tile in the cycle its last row leaves
  assign busy_o      = busy_q && !(pop && at_last);
  assign out_valid_o = busy_q;
  assign row_index_o = mmt_pkg::RowIdxW'(row_q);
  assign last_row_o  = at_last;

endmodule

// File: rtl/mmt_checker.sv
// ----------------------------------------------------------------------------
// mmt_checker
// Port-level checks on the result stream of the matmul tile.
// ----------------------------------------------------------------------------
module mmt_checker #(
  parameter int unsigned TileRows = mmt_pkg::DefTileRows
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mmt_pkg::RowIdxW-1:0]   row_index_i,
  input logic                          last_row_i
);

  localparam logic [mmt_pkg::RowIdxW-1:0] LastIdx = mmt_pkg::RowIdxW'(TileRows - 1);

  logic pop;
  assign pop = out_valid_i && out_ready_i;

  // A shown result stays until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // Rows of a tile come out back to back in ascending order
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !last_row_i |=> out_valid_i &&
      (row_index_i == $past(row_index_i) + mmt_pkg::RowIdxW'(1)))
    else $error("tile rows out of sequence");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_row_i == (row_index_i == LastIdx)))
    else $error("last_row does not match the final row");

  // A tile that follows straight after a last row opens at row zero
  a_tile_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && last_row_i |=> !out_valid_i || (row_index_i == '0))
    else $error("tile does not start at row zero");

endmodule

bind int8_matmul_tile_wrap16 mmt_checker #(
  .TileRows (TileRows)
) u_mmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .row_index_i (out_o.row_index),
  .last_row_i  (out_o.last_row)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the int8 matmul tile with 16-bit wrapping sums.
// ----------------------------------------------------------------------------
// A queue of reduction steps feeds a bursty driver. A monitor predicts the
// tile row sums for every accepted step and checks each result row, field by
// field, against the oldest prediction. The receiver stalls on a random
// pattern and holds off once for a long stretch. dot_length is reprogrammed
// between phases over APB while the tile is drained, including zero, the
// maximum, and a cut below the running step count.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TileRows   = mmt_pkg::DefTileRows;
  localparam int unsigned TileCols   = mmt_pkg::DefTileCols;
  localparam int unsigned MaxRows    = mmt_pkg::MaxRows;
  localparam int unsigned MaxCols    = mmt_pkg::MaxCols;
  localparam int unsigned DataW      = mmt_pkg::DataW;
  localparam int unsigned AccW       = mmt_pkg::AccW;
  localparam int unsigned LenW       = mmt_pkg::LenW;
  localparam int unsigned RowIdxW    = mmt_pkg::RowIdxW;
  localparam int unsigned ApbDataW   = mmt_pkg::ApbDataW;
  localparam int unsigned ApbAddrW   = mmt_pkg::ApbAddrW;
  localparam int          RandSteps  = 330;
  localparam int          StallLimit = 2000;
  localparam int          LongHold   = 200;
  localparam int          DrainWait  = 8;

  typedef struct packed {
    logic [MaxRows-1:0][DataW-1:0] a_row;
    logic [MaxCols-1:0][DataW-1:0] b_col;
  } mmt_step_t;

  typedef struct packed {
    logic [RowIdxW-1:0]           row_index;
    logic [MaxCols-1:0][AccW-1:0] sum_col;
    logic                         last_row;
  } mmt_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  mmt_in_if  in_if ();
  mmt_out_if out_if ();

  int8_matmul_tile_wrap16 dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  logic [AccW-1:0] tile_acc [MaxRows][MaxCols];
  logic [LenW-1:0] step_cnt;
  logic [LenW-1:0] cfg_dot_len;

  mmt_step_t step_q[$];
  mmt_row_t  row_sums_q[$];

  int mismatch_cnt;
  int rows_seen;
  int idle_cycles;
  int gap_left;
  int burst_left;
  int hold_left;
  bit long_hold_done;
  int stall_mode;
  int mode_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ApbAddrW-1:0] reg_addr(input mmt_pkg::mmt_reg_e idx);
    return ApbAddrW'({idx, 2'b00});
  endfunction

  task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
  endtask

  // Add one reduction step; close the tile when the step count reaches the length
  task automatic accumulate_step(input mmt_step_t s);
    logic signed [AccW-1:0] prod;
    logic [LenW:0]          next_cnt;
    logic [LenW-1:0]        limit_len;
    mmt_row_t               row;
    for (int r = 0; r < TileRows; r++) begin
      for (int c = 0; c < TileCols; c++) begin
        prod = $signed(s.a_row[r]) * $signed(s.b_col[c]);
        tile_acc[r][c] = tile_acc[r][c] + prod;
      end
    end
    next_cnt  = {1'b0, step_cnt} + 1'b1;
    limit_len = (cfg_dot_len == '0) ? LenW'(1) : cfg_dot_len;
    if (next_cnt < {1'b0, limit_len}) begin
      step_cnt = next_cnt[LenW-1:0];
    end else begin
      for (int r = 0; r < TileRows; r++) begin
        row.row_index = RowIdxW'(r);
        for (int c = 0; c < MaxCols; c++) begin
          row.sum_col[c] = (c < TileCols) ? tile_acc[r][c] : '0;
        end
        row.last_row = (r == TileRows - 1);
        row_sums_q.push_back(row);
      end
      for (int r = 0; r < MaxRows; r++) begin
        for (int c = 0; c < MaxCols; c++) tile_acc[r][c] = '0;
      end
      step_cnt = '0;
    end
  endtask

  function automatic logic [DataW-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h80;
      1:       return 8'h7f;
      2:       return 8'h00;
      default: return DataW'($urandom());
    endcase
  endfunction

  function automatic mmt_step_t uniform_step(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    mmt_step_t s;
    for (int r = 0; r < MaxRows; r++) s.a_row[r] = a;
    for (int c = 0; c < MaxCols; c++) s.b_col[c] = b;
    return s;
  endfunction

  task automatic queue_rand_steps(input int n);
    mmt_step_t s;
    for (int i = 0; i < n; i++) begin
      for (int r = 0; r < MaxRows; r++) s.a_row[r] = rand_byte();
      for (int c = 0; c < MaxCols; c++) s.b_col[c] = rand_byte();
      step_q.push_back(s);
    end
  endtask

  task automatic apb_write(input mmt_pkg::mmt_reg_e idx, input logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == mmt_pkg::RegDotLength) cfg_dot_len = data[LenW-1:0];
  endtask

  task automatic apb_check_len();
    logic [ApbDataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(mmt_pkg::RegDotLength);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== ApbDataW'(cfg_dot_len)) note_mismatch("dot_length readback", cfg_dot_len, got);
  endtask

  task automatic set_len(input logic [LenW-1:0] len);
    apb_write(mmt_pkg::RegDotLength, ApbDataW'(len));
    apb_check_len();
    @(negedge clk_i);
  endtask

  // Hold until every step is in and every row is out, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk_i); while (step_q.size() != 0 || in_if.valid || row_sums_q.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // Driver: bursts of random length with random gaps
  always @(posedge clk_i) begin
    mmt_step_t s;
    if (rst_ni && (!in_if.valid || in_if.ready)) begin
      if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (step_q.size() != 0) begin
        s = step_q.pop_front();
        in_if.valid  <= 1'b1;
        in_if.a_row0 <= s.a_row[0];
        in_if.a_row1 <= s.a_row[1];
        in_if.a_row2 <= s.a_row[2];
        in_if.a_row3 <= s.a_row[3];
        in_if.a_row4 <= s.a_row[4];
        in_if.a_row5 <= s.a_row[5];
        in_if.a_row6 <= s.a_row[6];
        in_if.a_row7 <= s.a_row[7];
        in_if.b_col0 <= s.b_col[0];
        in_if.b_col1 <= s.b_col[1];
        in_if.b_col2 <= s.b_col[2];
        in_if.b_col3 <= s.b_col[3];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall pattern, plus one long hold-off while steps keep coming
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!long_hold_done && rows_seen >= 160 && in_if.valid &&
                   step_q.size() != 0) begin
        long_hold_done <= 1'b1;
        hold_left      <= LongHold;
        out_if.ready   <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 2);
          mode_left  <= $urandom_range(10, 60);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: check rows against predictions, then predict from accepted steps
  always @(posedge clk_i) begin
    mmt_row_t  exp_row;
    mmt_step_t s;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        rows_seen <= rows_seen + 1;
        if (row_sums_q.size() == 0) begin
          note_mismatch("unexpected row, row_index", -1, out_if.row_index);
        end else begin
          exp_row = row_sums_q.pop_front();
          if (out_if.row_index !== exp_row.row_index)
            note_mismatch("row_index", exp_row.row_index, out_if.row_index);
          if (out_if.sum_col0 !== exp_row.sum_col[0])
            note_mismatch("sum_col0", $signed(exp_row.sum_col[0]), out_if.sum_col0);
          if (out_if.sum_col1 !== exp_row.sum_col[1])
            note_mismatch("sum_col1", $signed(exp_row.sum_col[1]), out_if.sum_col1);
          if (out_if.sum_col2 !== exp_row.sum_col[2])
            note_mismatch("sum_col2", $signed(exp_row.sum_col[2]), out_if.sum_col2);
          if (out_if.sum_col3 !== exp_row.sum_col[3])
            note_mismatch("sum_col3", $signed(exp_row.sum_col[3]), out_if.sum_col3);
          if (out_if.last_row !== exp_row.last_row)
            note_mismatch("last_row", exp_row.last_row, out_if.last_row);
        end
      end
      if (in_if.valid && in_if.ready) begin
        s.a_row = {in_if.a_row7, in_if.a_row6, in_if.a_row5, in_if.a_row4,
                   in_if.a_row3, in_if.a_row2, in_if.a_row1, in_if.a_row0};
        s.b_col = {in_if.b_col3, in_if.b_col2, in_if.b_col1, in_if.b_col0};
        accumulate_step(s);
      end
    end
  end

  // Watchdog on cycles with no transfer on any port
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [LenW-1:0] len;
    int              len_eff;
    int              n_steps;
    int              rand_queued;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.a_row0   = '0;
    in_if.a_row1   = '0;
    in_if.a_row2   = '0;
    in_if.a_row3   = '0;
    in_if.a_row4   = '0;
    in_if.a_row5   = '0;
    in_if.a_row6   = '0;
    in_if.a_row7   = '0;
    in_if.b_col0   = '0;
    in_if.b_col1   = '0;
    in_if.b_col2   = '0;
    in_if.b_col3   = '0;
    out_if.ready   = 1'b0;
    mismatch_cnt   = 0;
    rows_seen      = 0;
    idle_cycles    = 0;
    gap_left       = 0;
    burst_left     = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    stall_mode     = 0;
    mode_left      = 0;
    step_cnt       = '0;
    cfg_dot_len    = mmt_pkg::DotLengthRst;
    for (int r = 0; r < MaxRows; r++) begin
      for (int c = 0; c < MaxCols; c++) tile_acc[r][c] = '0;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset length: every step is a tile; operand extremes
    apb_check_len();
    @(negedge clk_i);
    step_q.push_back(uniform_step(8'h80, 8'h80));
    step_q.push_back(uniform_step(8'h7f, 8'h7f));
    step_q.push_back(uniform_step(8'h80, 8'h7f));
    step_q.push_back(uniform_step(8'h7f, 8'h80));
    step_q.push_back(uniform_step(8'h00, 8'hff));
    wait_drained();

    // Zero length acts as one
    set_len('0);
    queue_rand_steps(2);
    wait_drained();

    // Two steps of -128 * -128 wrap past the top of 16 bits
    set_len(LenW'(2));
    step_q.push_back(uniform_step(8'h80, 8'h80));
    step_q.push_back(uniform_step(8'h80, 8'h80));
    wait_drained();

    // Write to an unused index changes nothing
    apb_write(mmt_pkg::RegNone, ApbDataW'(5));
    apb_check_len();
    @(negedge clk_i);
    queue_rand_steps(4);
    wait_drained();

    // Maximum length, then cut below the running step count mid-tile
    set_len('1);
    queue_rand_steps(3);
    wait_drained();
    set_len(LenW'(2));
    queue_rand_steps(3);
    wait_drained();

    rand_queued = 0;
    while (rand_queued < RandSteps) begin
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = LenW'(1);
        2:       len = LenW'(2);
        3:       len = LenW'(7);
        4:       len = LenW'(8);
        5:       len = LenW'(9);
        default: len = LenW'($urandom_range(1, 24));
      endcase
      set_len(len);
      len_eff = (len == '0) ? 1 : int'(len);
      n_steps = len_eff * $urandom_range(1, 4);
      if ($urandom_range(0, 2) == 0) n_steps += $urandom_range(0, len_eff - 1);
      queue_rand_steps(n_steps);
      rand_queued += n_steps;
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && row_sums_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
